// ===== src/tsp_pkg.sv =====
`default_nettype none
package tsp_pkg;
  localparam int MaxCities = 16;
  localparam int CityW     = 4;
  localparam int CountW    = 5;
  localparam int DistW     = 24;
  localparam int MinW      = 32;
  localparam int BoundW    = 38;
  localparam int WtW       = 29;
  localparam int CmpW      = 40;
  localparam int DistDepth = MaxCities * MaxCities;
  localparam int StackDepth = 32;

  localparam logic [MinW-1:0] MinSentinel = {MinW{1'b1}};

  localparam logic [1:0] CfgCityCount = 2'd0;
  localparam logic [1:0] CfgStartCity = 2'd1;

  typedef struct packed {
    logic [CountW-1:0] cand;
    logic [BoundW-1:0] bound;
    logic [WtW-1:0]    weight;
    logic [CityW-1:0]  cur;
  } level_t;

  localparam int LevelW = $bits(level_t);
endpackage
`default_nettype wire

// ===== src/tsp_ram.sv =====
`default_nettype none
module tsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== src/tsp_branch_and_bound_search.sv =====
// Travelling-salesman branch-and-bound search.
// Matrix entries arrive on the input channel (row_city_i, col_city_i,
// distance_i, last_entry_i) and are written into the distance memory, one
// request per cycle while in_stall_o is low. A request with last_entry_i set
// holds in_stall_o high for the whole search: first a row-minimum pass that
// reads each matrix entry in turn, then a depth-first search whose length
// depends on the data, in which each candidate is read and checked against
// the bound and each step back reloads a level from the stack, limited by
// the single read port of the distance and stack memories.
// The best tour then leaves on the output channel as n + 1 requests, one per
// cycle unless out_stall_i is high, in which case the current request holds.
// Without a tour a single request with found_o low is given.
// Configuration writes (city_count, start_city) are taken while the block is
// idle, shown by cfg_ready_o. Reset returns the block to idle with the
// registers at 16 and 0; the distance memory keeps no reset value.
`default_nettype none
module tsp_branch_and_bound_search import tsp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CountW-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [CityW-1:0]  row_city_i,
  input  wire logic [CityW-1:0]  col_city_i,
  input  wire logic [DistW-1:0]  distance_i,
  input  wire logic              last_entry_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CountW-1:0]      position_o,
  output logic [CityW-1:0]       city_o,
  output logic [WtW-1:0]         tour_length_o,
  output logic                   found_o,
  output logic                   last_result_o
);
  localparam logic [3:0] SIdle = 4'd0,  SMRd = 4'd1,  SMWt = 4'd2,  SInit = 4'd3,
                         SLoop = 4'd4,  SCls = 4'd5,  SExp = 4'd6,  SCmp = 4'd7,
                         SCpR  = 4'd8,  SCpW = 4'd9,  SRld = 4'd10, SRlw = 4'd11,
                         SOut  = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [CountW-1:0] cc_q, cc_d, n_q, n_d;
  logic [CityW-1:0]  sc_q, sc_d, st_q, st_d;
  logic [CityW-1:0]  r_q, r_d, ki_q, ki_d;
  logic [MinW-1:0]   f_q, f_d, s_q, s_d;
  logic [BoundW-1:0] b0_q, b0_d;
  logic [CountW-1:0] lv_q, lv_d, k_q, k_d;
  level_t            top_q, top_d;
  logic [CityW-1:0]  i_q, i_d;
  logic [MinW-1:0]   drop_q, drop_d;
  logic [WtW-1:0]    w2_q, w2_d;
  logic [BoundW-1:0] b2_q, b2_d;
  logic [MinW-1:0]   best_q, best_d;
  logic              found_q, found_d;
  logic [MaxCities-1:0] vis_q, vis_d;
  logic [MinW-1:0]   rf_q [MaxCities];
  logic [MinW-1:0]   rs_q [MaxCities];
  logic [CityW-1:0]  bp_q [MaxCities+1];

  logic                 d_we, d_re;
  logic [7:0]           d_waddr, d_raddr;
  logic [DistW-1:0]     d_rdata;
  logic                 s_we, s_re;
  logic [CountW-1:0]    s_raddr;
  logic [LevelW-1:0]    s_rdata;
  level_t               s_entry;

  logic [MinW-1:0]   dext, f_n, s_n, rf_rd;
  logic [CityW-1:0]  rf_idx;
  logic [WtW-1:0]    res;
  logic [CmpW-1:0]   lhs, rhs;
  logic              rf_we, bp_we;
  logic [CountW-1:0] bp_idx;
  logic [CityW-1:0]  bp_val;

  tsp_ram #(.Width(DistW), .Depth(DistDepth)) u_dist (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(distance_i),
    .re_i(d_re), .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  tsp_ram #(.Width(LevelW), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(lv_q), .wdata_i(top_q),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  assign s_entry    = level_t'(s_rdata);
  assign dext       = {{(MinW-DistW){1'b0}}, d_rdata};
  assign rf_idx     = (state_q == SExp) ? i_q : top_q.cur;
  assign rf_rd      = rf_q[rf_idx];
  assign res        = top_q.weight + WtW'(d_rdata);
  assign lhs        = CmpW'(b2_q) + {{(CmpW-WtW-1){1'b0}}, w2_q, 1'b0};
  assign rhs        = {{(CmpW-MinW-1){1'b0}}, best_q, 1'b0};

  assign cfg_ready_o   = (state_q == SIdle);
  assign in_stall_o    = (state_q != SIdle);
  assign out_valid_o   = (state_q == SOut);
  assign position_o    = found_q ? k_q : '0;
  assign city_o        = found_q ? bp_q[k_q] : '0;
  assign tour_length_o = found_q ? best_q[WtW-1:0] : '0;
  assign found_o       = found_q;
  assign last_result_o = !found_q || (k_q == n_q);

  always_comb begin
    f_n = f_q;
    s_n = s_q;
    if (ki_q != r_q) begin
      if (dext <= f_q) begin
        s_n = f_q;
        f_n = dext;
      end else if (dext <= s_q && dext != f_q) begin
        s_n = dext;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cc_d = cc_q;  sc_d = sc_q;  n_d = n_q;  st_d = st_q;
    r_d = r_q;  ki_d = ki_q;  f_d = f_q;  s_d = s_q;  b0_d = b0_q;
    lv_d = lv_q;  k_d = k_q;  top_d = top_q;  i_d = i_q;  drop_d = drop_q;
    w2_d = w2_q;  b2_d = b2_q;  best_d = best_q;  found_d = found_q;  vis_d = vis_q;
    d_we = 1'b0;  d_re = 1'b0;
    d_waddr = {row_city_i, col_city_i};
    d_raddr = {r_q, ki_q};
    s_we = 1'b0;  s_re = 1'b0;  s_raddr = lv_q;
    rf_we = 1'b0;  bp_we = 1'b0;  bp_idx = k_q;  bp_val = top_q.cur;
    unique case (state_q)
      SIdle: begin
        if (cfg_valid_i) begin
          if (cfg_index_i == CfgCityCount) begin
            cc_d = cfg_data_i;
          end else if (cfg_index_i == CfgStartCity) begin
            sc_d = cfg_data_i[CityW-1:0];
          end
        end
        if (in_valid_i) begin
          d_we = 1'b1;
          if (last_entry_i) begin
            if (cc_q < CountW'(2)) begin
              n_d = CountW'(2);
            end else if (cc_q > CountW'(MaxCities)) begin
              n_d = CountW'(MaxCities);
            end else begin
              n_d = cc_q;
            end
            st_d = sc_q;
            r_d = '0;  ki_d = '0;
            f_d = MinSentinel;  s_d = MinSentinel;  b0_d = '0;
            k_d = '0;
            if (CountW'(sc_q) < n_d) begin
              state_d = SMRd;
            end else begin
              found_d = 1'b0;
              state_d = SOut;
            end
          end
        end
      end
      SMRd: begin
        d_re = 1'b1;
        state_d = SMWt;
      end
      SMWt: begin
        f_d = f_n;
        s_d = s_n;
        state_d = SMRd;
        if (CountW'(ki_q) == n_q - CountW'(1)) begin
          rf_we = 1'b1;
          b0_d = b0_q + BoundW'(f_n) + BoundW'(s_n);
          f_d = MinSentinel;
          s_d = MinSentinel;
          ki_d = '0;
          if (CountW'(r_q) == n_q - CountW'(1)) begin
            state_d = SInit;
          end else begin
            r_d = r_q + CityW'(1);
          end
        end else begin
          ki_d = ki_q + CityW'(1);
        end
      end
      SInit: begin
        vis_d = '0;
        vis_d[st_q] = 1'b1;
        lv_d = CountW'(1);
        top_d = '{cand: '0, bound: b0_q, weight: '0, cur: st_q};
        best_d = MinSentinel;
        state_d = SLoop;
      end
      SLoop: begin
        if (lv_q == n_q) begin
          d_re = 1'b1;
          d_raddr = {top_q.cur, st_q};
          state_d = SCls;
        end else if (top_q.cand >= n_q) begin
          vis_d[top_q.cur] = 1'b0;
          lv_d = lv_q - CountW'(1);
          if (lv_q == CountW'(1)) begin
            found_d = (best_q != MinSentinel);
            k_d = '0;
            state_d = SOut;
          end else begin
            state_d = SRld;
          end
        end else begin
          d_re = 1'b1;
          d_raddr = {top_q.cur, top_q.cand[CityW-1:0]};
          i_d = top_q.cand[CityW-1:0];
          top_d.cand = top_q.cand + CountW'(1);
          drop_d = (lv_q == CountW'(1)) ? rf_rd : rs_q[top_q.cur];
          state_d = SExp;
        end
      end
      SCls: begin
        if (d_rdata != '0 && MinW'(res) < best_q) begin
          best_d = MinW'(res);
          bp_we = 1'b1;
          bp_idx = n_q - CountW'(1);
          bp_val = top_q.cur;
          k_d = CountW'(1);
          state_d = SCpR;
        end else begin
          vis_d[top_q.cur] = 1'b0;
          lv_d = lv_q - CountW'(1);
          state_d = SRld;
        end
      end
      SCpR: begin
        s_re = 1'b1;
        s_raddr = k_q;
        state_d = SCpW;
      end
      SCpW: begin
        bp_we = 1'b1;
        bp_idx = k_q - CountW'(1);
        bp_val = s_entry.cur;
        if (k_q == n_q - CountW'(1)) begin
          vis_d[top_q.cur] = 1'b0;
          lv_d = lv_q - CountW'(1);
          state_d = SRld;
        end else begin
          k_d = k_q + CountW'(1);
          state_d = SCpR;
        end
      end
      SRld: begin
        s_re = 1'b1;
        state_d = SRlw;
      end
      SRlw: begin
        top_d = s_entry;
        state_d = SLoop;
      end
      SExp: begin
        if (d_rdata == '0 || vis_q[i_q]) begin
          state_d = SLoop;
        end else begin
          w2_d = res;
          b2_d = top_q.bound - (BoundW'(drop_q) + BoundW'(rf_rd));
          state_d = SCmp;
        end
      end
      SCmp: begin
        state_d = SLoop;
        if (lhs < rhs) begin
          s_we = 1'b1;
          vis_d[i_q] = 1'b1;
          lv_d = lv_q + CountW'(1);
          top_d = '{cand: '0, bound: b2_q, weight: w2_q, cur: i_q};
        end
      end
      SOut: begin
        if (!out_stall_i) begin
          if (last_result_o) begin
            state_d = SIdle;
          end else begin
            k_d = k_q + CountW'(1);
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cc_q    <= CountW'(MaxCities);
      sc_q    <= '0;
      n_q     <= CountW'(2);
      st_q    <= '0;
      lv_q    <= '0;
      k_q     <= '0;
      found_q <= 1'b0;
      best_q  <= MinSentinel;
      vis_q   <= '0;
    end else begin
      state_q <= state_d;
      cc_q    <= cc_d;
      sc_q    <= sc_d;
      n_q     <= n_d;
      st_q    <= st_d;
      lv_q    <= lv_d;
      k_q     <= k_d;
      found_q <= found_d;
      best_q  <= best_d;
      vis_q   <= vis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    ki_q   <= ki_d;
    f_q    <= f_d;
    s_q    <= s_d;
    b0_q   <= b0_d;
    top_q  <= top_d;
    i_q    <= i_d;
    drop_q <= drop_d;
    w2_q   <= w2_d;
    b2_q   <= b2_d;
    if (rf_we) begin
      rf_q[r_q] <= f_n;
      rs_q[r_q] <= s_n;
    end
    if (bp_we) begin
      bp_q[bp_idx] <= bp_val;
    end
    if (state_q == SCls && bp_we) begin
      bp_q[n_q] <= st_q;
    end
  end
endmodule
`default_nettype wire

// ===== src/tsp_checker.sv =====
`default_nettype none
module tsp_checker import tsp_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              cfg_ready_o,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [CountW-1:0] position_o,
  input wire logic              found_o,
  input wire logic              last_result_o
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("Input accepted while results are pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> last_result_o && position_o == '0)
    else $error("A run without a tour must give one result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=>
      out_valid_o && position_o == $past(position_o) + CountW'(1))
    else $error("Tour positions must follow one another.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !in_stall_o)
    else $error("Configuration is open only while idle.");
endmodule

bind tsp_branch_and_bound_search tsp_checker u_tsp_checker (
  .clk_i, .rst_ni, .cfg_ready_o, .in_stall_o, .out_valid_o, .out_stall_i,
  .position_o, .found_o, .last_result_o
);
`default_nettype wire
